/* src/rhsf_pkg.sv */
// Package: types, constants and the byte-code map of the rolling hash substring finder.
package rhsf_pkg;

	localparam int MAX_PATTERN_DEF     = 64;
	localparam int TEXT_COUNT_BITS_DEF = 20;
	localparam int HASH_W              = 31;
	localparam int CODE_W              = 7;
	localparam int POS_W               = 20;
	localparam int PROD_W              = 2 * HASH_W;
	localparam int RED_CNT_W           = $clog2(PROD_W);
	localparam int CFG_IDX_W           = 1;

	localparam logic [HASH_W-1:0] HASH_BASE_RESET    = 31'd67;
	localparam logic [HASH_W-1:0] HASH_MODULUS_RESET = 31'd1000000007;
	localparam logic [POS_W-1:0]  POS_MAX            = {POS_W{1'b1}};

	localparam logic [CODE_W-1:0] CODE_SPACE = 7'd27;
	localparam logic [CODE_W-1:0] CODE_UPPER = 7'd28;
	localparam logic [CODE_W-1:0] CODE_DIGIT = 7'd54;
	localparam logic [CODE_W-1:0] CODE_OTHER = 7'd65;

	localparam logic [CFG_IDX_W-1:0] REG_HASH_BASE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = 1'd1;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef enum logic [1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_TOO_LONG  = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
		logic       last_text;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] match_position;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] a;
		logic [HASH_W-1:0] b;
		logic [CODE_W-1:0] c;
		logic [HASH_W-1:0] m;
	} mm_req_t;

	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] result;
	} mm_resp_t;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_MUL,
		MM_ADD,
		MM_RED
	} mm_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_P_HASH,
		ST_P_POW,
		ST_T_PREV,
		ST_T_HASH,
		ST_T_CHECK,
		ST_T_OLD,
		ST_T_WIN,
		ST_FINISH
	} state_t;

	function automatic logic [CODE_W-1:0] code_of(input logic [7:0] c);
		logic [CODE_W-1:0] r;
		r = CODE_OTHER;
		if (c >= 8'h61 && c <= 8'h7a) r = CODE_W'(c - 8'h60);
		else if (c == 8'h20) r = CODE_SPACE;
		else if (c >= 8'h41 && c <= 8'h5a) r = CODE_W'(c - 8'h41) + CODE_UPPER;
		else if (c >= 8'h30 && c <= 8'h39) r = CODE_W'(c - 8'h30) + CODE_DIGIT;
		return r;
	endfunction

endpackage

/* src/rhsf_modmul.sv */
// Shared iterative unit: (a * b + c) mod m, one reduction bit per cycle.
module rhsf_modmul
	import rhsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mm_req_t  req,
	output mm_resp_t resp
);

	mm_state_t state_q, state_d;
	logic [HASH_W-1:0]    a_q, b_q, m_q;
	logic [CODE_W-1:0]    c_q;
	logic [PROD_W-1:0]    prod_s1, v_q;
	logic [HASH_W-1:0]    r_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [HASH_W:0]      r_shift, r_next;
	logic                 can_start;

	assign can_start = (state_q == MM_IDLE);
	assign r_shift   = {r_q, v_q[PROD_W-1]};
	assign r_next    = (r_shift >= {1'b0, m_q}) ? r_shift - {1'b0, m_q} : r_shift;

	always_comb begin
		state_d = state_q;
		case (state_q)
			MM_IDLE: if (req.start) state_d = MM_MUL;
			MM_MUL:  state_d = MM_ADD;
			MM_ADD:  state_d = MM_RED;
			MM_RED:  if (cnt_q == RED_CNT_W'(PROD_W - 1)) state_d = MM_IDLE;
			default: state_d = MM_IDLE;
		endcase
	end

	always_comb begin
		resp.done   = done_q;
		resp.result = r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == MM_RED) && (cnt_q == RED_CNT_W'(PROD_W - 1));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MM_IDLE: if (req.start) begin
				a_q <= req.a;
				b_q <= req.b;
				c_q <= req.c;
				m_q <= req.m;
			end
			MM_MUL: prod_s1 <= PROD_W'(a_q) * PROD_W'(b_q);
			MM_ADD: begin
				v_q   <= prod_s1 + PROD_W'(c_q);
				r_q   <= '0;
				cnt_q <= '0;
			end
			MM_RED: begin
				r_q   <= r_next[HASH_W-1:0];
				v_q   <= {v_q[PROD_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> can_start) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |=> !resp.done) else $error("done held");
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> (resp.result < m_q)) else $error("result not reduced");

endmodule

/* src/rolling_hash_substring_find.sv */
// Top level: Rabin-Karp substring finder with a prefix-hash ring and a shared multiply-reduce unit.
// A pattern byte takes two chained multiply-reduce passes.
// Until a match, a text byte takes one multiply-reduce pass, or two once a full window is checked,
// plus any wait for a held result; each pass runs the 62-step bit-serial reduction of the shared unit.
// The result is registered in ST_FINISH once the output is free; the item channel is not ready meanwhile.
// Reset clears job state and loads base 67 and modulus 1000000007; the ring is not cleared.
module rolling_hash_substring_find
	import rhsf_pkg::*;
#(
	parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
	parameter int TEXT_COUNT_BITS = TEXT_COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HASH_W-1:0]    cfg_data
);

	localparam int RING_DEPTH = MAX_PATTERN + 1;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int LEN_W      = $clog2(MAX_PATTERN + 2);
	localparam int CMP_W      = 34;
	localparam int SLOT_W     = RING_AW + 2;

	state_t state_q, state_d;

	logic [HASH_W-1:0]          base_q, modulus_q, m_eff;
	logic [HASH_W-1:0]          phash_q, bpow_q, h_q;
	logic [LEN_W-1:0]           len_q;
	logic [RING_AW-1:0]         slot_q, slot_next, old_slot;
	logic [TEXT_COUNT_BITS-1:0] tc_q;
	logic                       fin_q, found_q;
	logic                       kind_q, last_q;
	logic [CODE_W-1:0]          code_q;

	logic [HASH_W-1:0] ring_mem [RING_DEPTH];
	logic [HASH_W-1:0] ring_rd_q;
	logic              ring_we, ring_re;
	logic [RING_AW-1:0] ring_wa, ring_ra;
	logic [HASH_W-1:0] ring_wd;

	mm_req_t  mm_req;
	mm_resp_t mm_resp;

	logic [CMP_W-1:0]  tc_x, len_x, pos_x;
	logic [SLOT_W-1:0] old_sum;
	logic [HASH_W:0]   win_sum, win_red;
	logic              check_ok, win_hit, emit, out_free;

	rhsf_modmul u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mm_req),
		.resp  (mm_resp)
	);

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign m_eff      = (modulus_q == '0) ? HASH_W'(1) : modulus_q;

	assign slot_next = (slot_q == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign old_sum   = SLOT_W'(slot_q) + SLOT_W'(RING_DEPTH) - SLOT_W'(len_q);
	assign old_slot  = (old_sum >= SLOT_W'(RING_DEPTH)) ?
		RING_AW'(old_sum - SLOT_W'(RING_DEPTH)) : RING_AW'(old_sum);

	assign tc_x     = CMP_W'(tc_q);
	assign len_x    = CMP_W'(len_q);
	assign pos_x    = tc_x - len_x;
	assign check_ok = (len_q <= LEN_W'(MAX_PATTERN)) && (tc_x >= len_x);

	assign win_sum = {1'b0, h_q} + {1'b0, m_eff} - {1'b0, mm_resp.result};
	assign win_red = (win_sum >= {1'b0, m_eff}) ? win_sum - {1'b0, m_eff} : win_sum;
	assign win_hit = (win_red[HASH_W-1:0] == phash_q);

	assign out_free = !result_valid || result_ready;
	assign emit     = found_q || (last_q && !fin_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (kind_q == KIND_PATTERN) begin
					if (tc_q == '0 && !fin_q && len_q < LEN_W'(MAX_PATTERN))
						state_d = ST_P_HASH;
					else
						state_d = ST_IDLE;
				end else if (!fin_q) begin
					state_d = ST_T_PREV;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_P_HASH: if (mm_resp.done) state_d = ST_P_POW;
			ST_P_POW:  if (mm_resp.done) state_d = ST_IDLE;
			ST_T_PREV: state_d = ST_T_HASH;
			ST_T_HASH: if (mm_resp.done) state_d = ST_T_CHECK;
			ST_T_CHECK: state_d = check_ok ? ST_T_OLD : ST_FINISH;
			ST_T_OLD:  state_d = ST_T_WIN;
			ST_T_WIN:  if (mm_resp.done) state_d = ST_FINISH;
			ST_FINISH: if (!emit || out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mm_req  = '{start: 1'b0, a: '0, b: base_q, c: '0, m: m_eff};
		ring_we = 1'b0;
		ring_wa = '0;
		ring_wd = '0;
		ring_re = 1'b0;
		ring_ra = slot_q;
		case (state_q)
			ST_DISPATCH: begin
				if (kind_q == KIND_PATTERN) begin
					mm_req.start = (tc_q == '0) && !fin_q && (len_q < LEN_W'(MAX_PATTERN));
					mm_req.a     = phash_q;
					mm_req.c     = code_q;
				end else begin
					ring_re = 1'b1;
					ring_we = (tc_q == '0) && !fin_q;
				end
			end
			ST_P_HASH: begin
				mm_req.start = mm_resp.done;
				mm_req.a     = bpow_q;
			end
			ST_T_PREV: begin
				mm_req.start = 1'b1;
				mm_req.a     = (tc_q == '0) ? '0 : ring_rd_q;
				mm_req.c     = code_q;
			end
			ST_T_HASH: begin
				ring_we = mm_resp.done;
				ring_wa = slot_next;
				ring_wd = mm_resp.result;
			end
			ST_T_CHECK: begin
				ring_re = 1'b1;
				ring_ra = old_slot;
			end
			ST_T_OLD: begin
				mm_req.start = 1'b1;
				mm_req.a     = ring_rd_q;
				mm_req.b     = bpow_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_wa] <= ring_wd;
		if (ring_re) ring_rd_q <= ring_mem[ring_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_q       <= HASH_BASE_RESET;
			modulus_q    <= HASH_MODULUS_RESET;
			phash_q      <= '0;
			bpow_q       <= HASH_W'(1);
			len_q        <= '0;
			slot_q       <= '0;
			tc_q         <= '0;
			fin_q        <= 1'b0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_HASH_BASE:    base_q    <= cfg_data;
					REG_HASH_MODULUS: modulus_q <= cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready && !(state_q == ST_FINISH && emit))
				result_valid <= 1'b0;
			case (state_q)
				ST_DISPATCH: begin
					found_q <= 1'b0;
					if (kind_q == KIND_PATTERN && tc_q == '0 && !fin_q &&
						len_q >= LEN_W'(MAX_PATTERN))
						len_q <= LEN_W'(MAX_PATTERN + 1);
				end
				ST_P_HASH: if (mm_resp.done) phash_q <= mm_resp.result;
				ST_P_POW: if (mm_resp.done) begin
					bpow_q <= mm_resp.result;
					len_q  <= len_q + 1'b1;
				end
				ST_T_HASH: if (mm_resp.done) begin
					slot_q <= slot_next;
					if (tc_q != {TEXT_COUNT_BITS{1'b1}}) tc_q <= tc_q + 1'b1;
				end
				ST_T_WIN: if (mm_resp.done && win_hit) begin
					fin_q   <= 1'b1;
					found_q <= 1'b1;
				end
				ST_FINISH: if (!emit || out_free) begin
					if (emit) result_valid <= 1'b1;
					if (last_q) begin
						phash_q <= '0;
						bpow_q  <= HASH_W'(1);
						len_q   <= '0;
						slot_q  <= '0;
						tc_q    <= '0;
						fin_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			kind_q <= item.kind;
			code_q <= code_of(item.char_byte);
			last_q <= item.kind & item.last_text;
		end
		if (state_q == ST_T_HASH && mm_resp.done) h_q <= mm_resp.result;
		if (state_q == ST_FINISH && emit && out_free) begin
			if (found_q) begin
				result.status         <= STATUS_FOUND;
				result.match_position <= (pos_x > CMP_W'(POS_MAX)) ?
					POS_MAX : pos_x[POS_W-1:0];
			end else begin
				result.status         <= (len_q > LEN_W'(MAX_PATTERN)) ?
					STATUS_TOO_LONG : STATUS_NOT_FOUND;
				result.match_position <= '0;
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < RING_AW'(RING_DEPTH - 1) || slot_q == RING_AW'(RING_DEPTH - 1))
		else $error("ring slot out of range");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_PATTERN + 1)) else $error("pattern length out of range");
	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (tc_q != '0)) else $error("finished with no text");

endmodule

/* bench/tb_top.sv */
// Testbench for the rolling hash substring finder: random pattern/text jobs checked by a scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import rhsf_pkg::*;

	localparam int RING_LEN   = MAX_PATTERN_DEF + 1;
	localparam int DRAIN_WAIT = 400;
	localparam int STALL_MAX  = 6000;

	class hash_search_board;
		result_t           pending[$];
		longint unsigned   base_reg, mod_reg;
		longint unsigned   pat_hash, pat_pow, ring[RING_LEN];
		int                pat_len, slot, txt_count;
		bit                done_job;
		int                errors, n_found, n_missing, n_too_long;

		function new();
			base_reg = HASH_BASE_RESET;
			mod_reg  = HASH_MODULUS_RESET;
			foreach (ring[i]) ring[i] = 0;
			clear_job();
		endfunction

		function void clear_job();
			pat_hash  = 0;
			pat_len   = 0;
			pat_pow   = 1;
			slot      = 0;
			txt_count = 0;
			done_job  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] v);
			if (idx == REG_HASH_BASE) base_reg = v;
			else mod_reg = v;
		endfunction

		function longint unsigned char_code(logic [7:0] c);
			if (c >= "a" && c <= "z") return c - "a" + 1;
			if (c == " ") return 27;
			if (c >= "A" && c <= "Z") return c - "A" + 28;
			if (c >= "0" && c <= "9") return c - "0" + 54;
			return 65;
		endfunction

		function void note_item(item_t it);
			longint unsigned m, prev, h, old, win;
			int nslot;
			result_t r;
			m = (mod_reg == 0) ? 1 : mod_reg;
			if (it.kind == KIND_PATTERN) begin
				if (txt_count == 0 && !done_job) begin
					if (pat_len < MAX_PATTERN_DEF) begin
						pat_hash = (pat_hash * base_reg + char_code(it.char_byte)) % m;
						pat_pow  = (pat_pow * base_reg) % m;
						pat_len++;
					end else begin
						pat_len = MAX_PATTERN_DEF + 1;
					end
				end
				return;
			end
			if (!done_job) begin
				if (txt_count == 0) begin
					slot    = 0;
					ring[0] = 0;
				end
				prev        = ring[slot];
				nslot       = (slot + 1) % RING_LEN;
				h           = (prev * base_reg + char_code(it.char_byte)) % m;
				ring[nslot] = h;
				slot        = nslot;
				if (txt_count < (1 << TEXT_COUNT_BITS_DEF) - 1) txt_count++;
				if (pat_len <= MAX_PATTERN_DEF && txt_count >= pat_len) begin
					old = ring[(nslot + RING_LEN - pat_len) % RING_LEN] % m;
					win = (h + m - (old * (pat_pow % m)) % m) % m;
					if (win == pat_hash) begin
						r.status         = STATUS_FOUND;
						r.match_position = (txt_count - pat_len > POS_MAX) ?
							POS_MAX : POS_W'(txt_count - pat_len);
						pending.push_back(r);
						done_job = 1;
					end
				end
			end
			if (it.last_text) begin
				if (!done_job) begin
					r.status         = (pat_len > MAX_PATTERN_DEF) ? STATUS_TOO_LONG : STATUS_NOT_FOUND;
					r.match_position = '0;
					pending.push_back(r);
				end
				clear_job();
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d pos=%0d", $time, r.status,
					r.match_position);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.status != e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
				errors++;
			end
			if (r.match_position != e.match_position) begin
				$display("%0t: position expected %0d actual %0d", $time, e.match_position,
					r.match_position);
				errors++;
			end
			case (e.status)
				STATUS_FOUND:     n_found++;
				STATUS_NOT_FOUND: n_missing++;
				default:          n_too_long++;
			endcase
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              item_valid, item_ready;
	item_t             item;
	logic              result_valid, result_ready;
	result_t           result;
	logic              cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HASH_W-1:0] cfg_data;

	hash_search_board sb = new();
	bit tx_steady, rx_steady, hold_req;
	int stall_count, items_sent, jobs_run;

	rolling_hash_substring_find i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always begin
		@(posedge clk);
		if (hold_req) begin
			hold_req = 0;
			result_ready <= 1'b0;
			repeat (2000) @(posedge clk);
		end else begin
			result_ready <= rx_steady || ($urandom_range(99) >= 24);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_MAX) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	task automatic push_item(input logic k, input logic [7:0] b, input logic l);
		item_t it;
		it = '{kind: k, char_byte: b, last_text: l};
		if (!tx_steady && $urandom_range(99) < 24) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] v);
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int sel;
		sel = $urandom_range(99);
		if (sel < 45) return 8'("a" + $urandom_range(2));
		if (sel < 60) return 8'("a" + $urandom_range(25));
		if (sel < 70) return 8'("A" + $urandom_range(25));
		if (sel < 78) return 8'("0" + $urandom_range(9));
		if (sel < 82) return " ";
		return 8'($urandom_range(255));
	endfunction

	task automatic run_job(input int plen, input int tlen, input bit embed, input bit noise);
		logic [7:0] pat[], txt[];
		int at;
		pat = new[plen];
		txt = new[tlen];
		foreach (pat[i]) pat[i] = pick_char();
		foreach (txt[i]) txt[i] = pick_char();
		if (embed && plen > 0 && plen <= tlen) begin
			at = $urandom_range(tlen - plen);
			foreach (pat[i]) txt[at + i] = pat[i];
		end
		foreach (pat[i]) push_item(KIND_PATTERN, pat[i], 1'($urandom_range(1)));
		foreach (txt[i]) begin
			push_item(KIND_TEXT, txt[i], i == tlen - 1);
			if (noise && i == 0 && tlen > 1) begin
				push_item(KIND_PATTERN, pick_char(), 1'($urandom_range(1)));
				items_sent--;
			end
		end
		jobs_run++;
	endtask

	task automatic random_config();
		logic [HASH_W-1:0] b, m;
		case ($urandom_range(3))
			0: b = 31'd1;
			1: b = 31'd2147483646;
			2: b = HASH_BASE_RESET;
			default: b = 31'($urandom_range(32'h7FFF_FFFE, 1));
		endcase
		case ($urandom_range(4))
			0: m = 31'd2;
			1: m = 31'd2147483647;
			2: m = HASH_MODULUS_RESET;
			3: m = 31'($urandom_range(97, 2));
			default: m = 31'($urandom_range(32'h7FFF_FFFF, 2));
		endcase
		write_reg(REG_HASH_BASE, b);
		write_reg(REG_HASH_MODULUS, m);
	endtask

	initial begin
		int plen, sel;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		tx_steady    = 0;
		rx_steady    = 0;
		hold_req     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the byte, empty pattern, over-long pattern, match on last byte
		push_item(KIND_PATTERN, 8'h00, 1'b1);
		push_item(KIND_PATTERN, 8'hFF, 1'b0);
		push_item(KIND_TEXT, 8'h00, 1'b0);
		push_item(KIND_TEXT, 8'hFF, 1'b1);
		push_item(KIND_TEXT, "z", 1'b1);
		push_item(KIND_PATTERN, "Z", 1'b0);
		push_item(KIND_PATTERN, "9", 1'b0);
		push_item(KIND_TEXT, " ", 1'b0);
		push_item(KIND_TEXT, "A", 1'b0);
		push_item(KIND_TEXT, "Z", 1'b0);
		push_item(KIND_TEXT, "9", 1'b1);
		push_item(KIND_PATTERN, "a", 1'b0);
		push_item(KIND_TEXT, "0", 1'b0);
		push_item(KIND_TEXT, "a", 1'b0);
		push_item(KIND_TEXT, "b", 1'b1);
		run_job(MAX_PATTERN_DEF + 1, 2, 0, 0);
		run_job(MAX_PATTERN_DEF, MAX_PATTERN_DEF + 3, 1, 1);

		write_reg(REG_HASH_BASE, 31'd2147483646);
		write_reg(REG_HASH_MODULUS, 31'd2);
		run_job(3, 6, 0, 0);
		write_reg(REG_HASH_BASE, 31'd1);
		write_reg(REG_HASH_MODULUS, 31'd2147483647);
		run_job(2, 5, 1, 0);

		while (items_sent < 1000) begin
			if (jobs_run % 40 == 0) random_config();
			tx_steady = (jobs_run >= 60 && jobs_run < 80);
			rx_steady = tx_steady;
			if (jobs_run == 50) hold_req = 1;
			if (jobs_run == 90) drain();
			sel = $urandom_range(99);
			if (sel < 5) plen = 0;
			else if (sel < 10) plen = $urandom_range(MAX_PATTERN_DEF + 6, MAX_PATTERN_DEF + 1);
			else if (sel < 30) plen = $urandom_range(MAX_PATTERN_DEF, 9);
			else plen = $urandom_range(8, 1);
			run_job(plen, (plen > 12 ? 12 : plen) + $urandom_range(12, 1),
				$urandom_range(99) < 60, $urandom_range(99) < 10);
		end
		tx_steady = 0;
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d jobs, %0d items: %0d found, %0d not found, %0d too long.",
			jobs_run, items_sent, sb.n_found, sb.n_missing, sb.n_too_long);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
